@@ rtl/hstm_pkg.sv @@
// hstm_pkg: shared types and constants for the hdr to sdr tone map block
// no dependencies
`default_nettype none
package hstm_pkg;
    localparam int CODE_W = 10;
    localparam int DELTA_W = 16;
    localparam int COEF_W = 18;
    localparam int SCALE_W = 10;
    localparam int LANES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_RED_COEF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_COEF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GCB_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GCR_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CB_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CR_SCALE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MAX = 3'd7;

    typedef struct packed {
        logic        [0:0]  req_type;
        logic        [15:0] cb_code;
        logic        [15:0] cr_code;
        logic        [15:0] y_top_left;
        logic        [15:0] y_top_right;
        logic        [15:0] y_bottom_left;
        logic        [15:0] y_bottom_right;
        logic        [9:0]  lut_index;
        logic        [7:0]  lut_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_y_top_left;
        logic [7:0] out_y_top_right;
        logic [7:0] out_y_bottom_left;
        logic [7:0] out_y_bottom_right;
        logic [7:0] out_cb;
        logic [7:0] out_cr;
    } out_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]  red_coef;
        logic signed [COEF_W-1:0]  blue_coef;
        logic signed [COEF_W-1:0]  gcb_coef;
        logic signed [COEF_W-1:0]  gcr_coef;
        logic        [SCALE_W-1:0] cb_scale;
        logic        [SCALE_W-1:0] cr_scale;
        logic        [7:0]         chroma_min;
        logic        [7:0]         chroma_max;
    } cfg_t;

    // lookup index: 16-bit wrapped luma plus delta, clamped to 0..1023
    function automatic logic [CODE_W-1:0] clamp_index(input logic [CODE_W-1:0] y,
                                                      input logic signed [DELTA_W-1:0] d);
        logic signed [DELTA_W-1:0] s;
        s = $signed({6'd0, y}) + d;
        if (s < 0)
            return '0;
        else if (s > 16'sd1023)
            return 10'd1023;
        else
            return s[CODE_W-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/hstm_if.sv @@
// hstm_if: valid/ready stream channel carrying one payload item
// depends on nothing; payload type given by parameter
`default_nettype none
interface hstm_if #(parameter type item_t = logic) (input wire logic clk);
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/hstm_lane.sv @@
// hstm_lane: one pixel lane, three curve lookups then the luma dot product
// depends on hstm_pkg; holds its own three copies of the curve table
`default_nettype none
module hstm_lane (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [hstm_pkg::CODE_W-1:0]          wr_addr,
    input  wire logic [7:0]                           wr_data,
    input  wire logic [hstm_pkg::CODE_W-1:0]          y,
    input  wire logic signed [hstm_pkg::DELTA_W-1:0]  dr,
    input  wire logic signed [hstm_pkg::DELTA_W-1:0]  dg,
    input  wire logic signed [hstm_pkg::DELTA_W-1:0]  db,
    input  wire logic                                 en,
    output logic [7:0]                                r,
    output logic [7:0]                                g,
    output logic [7:0]                                b,
    output logic [7:0]                                luma
);
    import hstm_pkg::*;

    // three read ports: one memory copy per color, written together
    logic [7:0] mem_r [1024];
    logic [7:0] mem_g [1024];
    logic [7:0] mem_b [1024];
    logic [7:0] r_reg, g_reg, b_reg;
    logic [7:0] luma_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_r[wr_addr] <= wr_data;
            mem_g[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
        end
        if (en)
        begin
            r_reg <= mem_r[clamp_index(y, dr)];
            g_reg <= mem_g[clamp_index(y, dg)];
            b_reg <= mem_b[clamp_index(y, db)];
            luma_reg <= 8'((18'd67 * r_reg + 18'd174 * g_reg + 18'd15 * b_reg + 18'd128) >> 8);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r <= r_reg;
            g <= g_reg;
            b <= b_reg;
        end
    end
    assign luma = luma_reg;
endmodule
`default_nettype wire

@@ rtl/hstm_chroma.sv @@
// hstm_chroma: merge stage, gamut rows and chroma re-encode from top-left lane
// depends on hstm_pkg
`default_nettype none
module hstm_chroma (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire hstm_pkg::cfg_t   cfg,
    input  wire logic [7:0]       r,
    input  wire logic [7:0]       g,
    input  wire logic [7:0]       b,
    input  wire logic [7:0]       luma,
    output logic [7:0]            cb,
    output logic [7:0]            cr
);
    import hstm_pkg::*;

    logic signed [19:0] rs, bs;
    logic [7:0] r709_reg, b709_reg, y_reg;

    always_comb
    begin
        rs = (20'sd425 * $signed({12'd0, r}) - 20'sd150 * $signed({12'd0, g})
              - 20'sd19 * $signed({12'd0, b}) + 20'sd128) >>> 8;
        bs = (-20'sd5 * $signed({12'd0, r}) - 20'sd26 * $signed({12'd0, g})
              + 20'sd287 * $signed({12'd0, b}) + 20'sd128) >>> 8;
    end

    function automatic logic [7:0] enc(input logic [7:0] p, input logic [7:0] yy,
                                       input logic [SCALE_W-1:0] sc,
                                       input logic [7:0] lo, input logic [7:0] hi);
        logic signed [21:0] c;
        c = 22'sd128 + (($signed({14'd0, p}) - $signed({14'd0, yy}))
             * $signed({12'd0, sc}) + 22'sd128 >>> 8);
        if (c < $signed({14'd0, lo})) c = $signed({14'd0, lo});
        if (c > $signed({14'd0, hi})) c = $signed({14'd0, hi});
        return c[7:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r709_reg <= (rs < 0) ? 8'd0 : (rs > 20'sd255) ? 8'd255 : rs[7:0];
            b709_reg <= (bs < 0) ? 8'd0 : (bs > 20'sd255) ? 8'd255 : bs[7:0];
            y_reg <= luma;
            cb <= enc(b709_reg, y_reg, cfg.cb_scale, cfg.chroma_min, cfg.chroma_max);
            cr <= enc(r709_reg, y_reg, cfg.cr_scale, cfg.chroma_min, cfg.chroma_max);
        end
    end
endmodule
`default_nettype wire

@@ rtl/hdr_to_sdr_tonemap_2x2.sv @@
// hdr_to_sdr_tonemap_2x2: top level, deltas, four pixel lanes, chroma merge
// depends on hstm_pkg, hstm_if, hstm_lane, hstm_chroma
//
// usage: items enter on in_ch (valid/ready). req_type 1 writes one curve
// byte and yields no result; req_type 0 carries a 2x2 block and yields one
// result item on out_ch. cfg_we/cfg_index/cfg_data write registers 0..7;
// the user must write them only while idle, the block does not enforce it.
// the pipeline takes one item per cycle while not held: delta multiply,
// curve read, luma dot, gamut rows, chroma encode (5 stages). the whole
// pipe advances as one unit; it holds when the output stage is full and
// not taken, and in_ch.ready is low only then, so a full output does not
// block while it drains. each lane holds three curve copies (one per
// color lookup). reset clears valid bits and config registers; curve
// contents are undefined until written and an unwritten entry reads back
// as anything.
`default_nettype none
module hdr_to_sdr_tonemap_2x2 (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    hstm_if.sink                                   in_ch,
    hstm_if.source                                 out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [hstm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hstm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hstm_pkg::*;

    localparam int STAGES = 5;

    cfg_t cfg_reg;
    logic [STAGES-1:0] vld_reg;
    logic adv;
    in_item_t it;

    assign it = in_ch.data;
    // pipe moves when the last stage is empty or being taken
    assign adv = !vld_reg[STAGES-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_coef <= '0;
            cfg_reg.blue_coef <= '0;
            cfg_reg.gcb_coef <= '0;
            cfg_reg.gcr_coef <= '0;
            cfg_reg.cb_scale <= 10'd256;
            cfg_reg.cr_scale <= 10'd256;
            cfg_reg.chroma_min <= 8'd16;
            cfg_reg.chroma_max <= 8'd240;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_COEF:   cfg_reg.red_coef <= cfg_data;
                REG_BLUE_COEF:  cfg_reg.blue_coef <= cfg_data;
                REG_GCB_COEF:   cfg_reg.gcb_coef <= cfg_data;
                REG_GCR_COEF:   cfg_reg.gcr_coef <= cfg_data;
                REG_CB_SCALE:   cfg_reg.cb_scale <= cfg_data[SCALE_W-1:0];
                REG_CR_SCALE:   cfg_reg.cr_scale <= cfg_data[SCALE_W-1:0];
                REG_CHROMA_MIN: cfg_reg.chroma_min <= cfg_data[7:0];
                REG_CHROMA_MAX: cfg_reg.chroma_max <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    logic [STAGES-1:0] vld_next;
    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
            vld_next = {vld_reg[STAGES-2:0],
                        in_ch.valid && (it.req_type == 1'b0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // stage 1: q15 deltas
    logic signed [CODE_W:0] cbc, crc;
    logic signed [DELTA_W-1:0] dr_reg, dg_reg, db_reg;
    logic [CODE_W-1:0] y_reg [LANES];
    logic signed [29:0] pr, pb, pgb, pgr;
    logic signed [14:0] tr, tb, tgb, tgr;

    assign cbc = $signed({1'b0, it.cb_code[CODE_W-1:0]}) - 11'sd512;
    assign crc = $signed({1'b0, it.cr_code[CODE_W-1:0]}) - 11'sd512;
    assign pr = (crc * cfg_reg.red_coef + 30'sd16384) >>> 15;
    assign pb = (cbc * cfg_reg.blue_coef + 30'sd16384) >>> 15;
    assign pgb = (cbc * cfg_reg.gcb_coef + 30'sd16384) >>> 15;
    assign pgr = (crc * cfg_reg.gcr_coef + 30'sd16384) >>> 15;
    assign tr = pr[14:0];
    assign tb = pb[14:0];
    assign tgb = pgb[14:0];
    assign tgr = pgr[14:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dr_reg <= {tr[14], tr};
            db_reg <= {tb[14], tb};
            dg_reg <= DELTA_W'(pgb[DELTA_W-1:0] + pgr[DELTA_W-1:0]);
            y_reg[0] <= it.y_top_left[CODE_W-1:0];
            y_reg[1] <= it.y_top_right[CODE_W-1:0];
            y_reg[2] <= it.y_bottom_left[CODE_W-1:0];
            y_reg[3] <= it.y_bottom_right[CODE_W-1:0];
        end
    end

    logic wr;
    assign wr = in_ch.valid && adv && (it.req_type == 1'b1);

    logic [7:0] lr [LANES];
    logic [7:0] lg [LANES];
    logic [7:0] lb [LANES];
    logic [7:0] ly [LANES];
    logic [7:0] yd_reg [LANES];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        hstm_lane u_lane (
            .clk(clk), .wr_en(wr), .wr_addr(it.lut_index), .wr_data(it.lut_value),
            .y(y_reg[i]), .dr(dr_reg), .dg(dg_reg), .db(db_reg), .en(adv),
            .r(lr[i]), .g(lg[i]), .b(lb[i]), .luma(ly[i])
        );
    end

    // luma lanes pass through yd_reg and yd2_reg to line up with chroma
    logic [7:0] yd2_reg [LANES];
    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < LANES; i++)
            begin
                yd_reg[i] <= ly[i];
                yd2_reg[i] <= yd_reg[i];
            end
    end

    logic [7:0] cb, cr;
    hstm_chroma u_chroma (
        .clk(clk), .en(adv), .cfg(cfg_reg), .r(lr[0]), .g(lg[0]), .b(lb[0]),
        .luma(ly[0]), .cb(cb), .cr(cr)
    );

    assign out_ch.valid = vld_reg[STAGES-1];
    assign out_ch.data.out_y_top_left = yd2_reg[0];
    assign out_ch.data.out_y_top_right = yd2_reg[1];
    assign out_ch.data.out_y_bottom_left = yd2_reg[2];
    assign out_ch.data.out_y_bottom_right = yd2_reg[3];
    assign out_ch.data.out_cb = cb;
    assign out_ch.data.out_cr = cr;
endmodule
`default_nettype wire

@@ sim/hdr_to_sdr_tonemap_2x2_tb.sv @@
// hdr_to_sdr_tonemap_2x2_tb: self-checking bench for the 2x2 hdr to sdr tone map block
// depends on hstm_pkg, hstm_if and the rtl top level; predicts block results (typed for
// some directed rows); drives curve loads, blocks and register phases with random stalls
`default_nettype none
module hdr_to_sdr_tonemap_2x2_tb;
    import hstm_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        has_exp;
        out_item_t exp;
    } dir_row_t;

    localparam int MAX_CYCLES = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hstm_if #(.item_t(in_item_t)) in_ch (clk);
    hstm_if #(.item_t(out_item_t)) out_ch (clk);

    hdr_to_sdr_tonemap_2x2 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block state
    logic [7:0] curve_copy [1024];
    cfg_t shadow_cfg;
    out_item_t pending_q [$];
    bit fail_seen;
    bit quiet_mode;
    bit hold_req;
    int cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES)
        begin
            $display("hdr_to_sdr_tonemap_2x2 verification failed");
            $finish;
        end
    end

    function automatic longint q15_term(input logic [9:0] code, input logic signed [17:0] coef);
        longint p;
        p = (longint'(code) - 512) * longint'(coef) + 16384;
        return p >>> 15;
    endfunction

    function automatic longint wrap16(input longint v);
        logic signed [15:0] t;
        t = v[15:0];
        return longint'(t);
    endfunction

    function automatic logic [7:0] curve_read(input logic [9:0] y, input longint d);
        longint s;
        s = wrap16(longint'(y) + d);
        if (s < 0)
            s = 0;
        if (s > 1023)
            s = 1023;
        return curve_copy[s];
    endfunction

    function automatic logic [7:0] chroma_enc(input longint prim, input logic [7:0] y,
                                              input logic [9:0] scale);
        longint c;
        c = 128 + (((prim - longint'(y)) * longint'(scale) + 128) >>> 8);
        if (c < longint'(shadow_cfg.chroma_min))
            c = shadow_cfg.chroma_min;
        if (c > longint'(shadow_cfg.chroma_max))
            c = shadow_cfg.chroma_max;
        return c[7:0];
    endfunction

    function automatic longint clamp_byte(input longint v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    function automatic out_item_t tone_map(input in_item_t it);
        out_item_t res;
        logic [9:0] ys [4];
        logic [7:0] lumas [4];
        logic [7:0] r0, g0, b0, r, g, b;
        longint dr, db, dg, r709, b709;
        ys[0] = it.y_top_left[9:0];
        ys[1] = it.y_top_right[9:0];
        ys[2] = it.y_bottom_left[9:0];
        ys[3] = it.y_bottom_right[9:0];
        dr = wrap16(q15_term(it.cr_code[9:0], shadow_cfg.red_coef));
        db = wrap16(q15_term(it.cb_code[9:0], shadow_cfg.blue_coef));
        dg = wrap16(q15_term(it.cb_code[9:0], shadow_cfg.gcb_coef)
                    + q15_term(it.cr_code[9:0], shadow_cfg.gcr_coef));
        for (int i = 0; i < 4; i++)
        begin
            r = curve_read(ys[i], dr);
            g = curve_read(ys[i], dg);
            b = curve_read(ys[i], db);
            lumas[i] = 8'((67 * int'(r) + 174 * int'(g) + 15 * int'(b) + 128) >> 8);
            if (i == 0)
            begin
                r0 = r;
                g0 = g;
                b0 = b;
            end
        end
        r709 = clamp_byte((425 * longint'(r0) - 150 * longint'(g0) - 19 * longint'(b0)
                           + 128) >>> 8);
        b709 = clamp_byte((-5 * longint'(r0) - 26 * longint'(g0) + 287 * longint'(b0)
                           + 128) >>> 8);
        res.out_y_top_left = lumas[0];
        res.out_y_top_right = lumas[1];
        res.out_y_bottom_left = lumas[2];
        res.out_y_bottom_right = lumas[3];
        res.out_cb = chroma_enc(b709, lumas[0], shadow_cfg.cb_scale);
        res.out_cr = chroma_enc(r709, lumas[0], shadow_cfg.cr_scale);
        return res;
    endfunction

    // typed expectation of the current directed row, used instead of the prediction
    bit use_typed;
    out_item_t typed_exp;

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            if (in_ch.data.req_type == 1'b1)
                curve_copy[in_ch.data.lut_index] = in_ch.data.lut_value;
            else if (use_typed)
                pending_q.push_back(typed_exp);
            else
                pending_q.push_back(tone_map(in_ch.data));
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, out_ch.data);
                fail_seen = 1'b1;
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.out_y_top_left !== out_ch.data.out_y_top_left)
                    $display("%0t: out_y_top_left exp %0d got %0d", $time,
                             want.out_y_top_left, out_ch.data.out_y_top_left);
                if (want.out_y_top_right !== out_ch.data.out_y_top_right)
                    $display("%0t: out_y_top_right exp %0d got %0d", $time,
                             want.out_y_top_right, out_ch.data.out_y_top_right);
                if (want.out_y_bottom_left !== out_ch.data.out_y_bottom_left)
                    $display("%0t: out_y_bottom_left exp %0d got %0d", $time,
                             want.out_y_bottom_left, out_ch.data.out_y_bottom_left);
                if (want.out_y_bottom_right !== out_ch.data.out_y_bottom_right)
                    $display("%0t: out_y_bottom_right exp %0d got %0d", $time,
                             want.out_y_bottom_right, out_ch.data.out_y_bottom_right);
                if (want.out_cb !== out_ch.data.out_cb)
                    $display("%0t: out_cb exp %0d got %0d", $time,
                             want.out_cb, out_ch.data.out_cb);
                if (want.out_cr !== out_ch.data.out_cr)
                    $display("%0t: out_cr exp %0d got %0d", $time,
                             want.out_cr, out_ch.data.out_cr);
                if (want !== out_ch.data)
                    fail_seen = 1'b1;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(input in_item_t it);
        if (!quiet_mode && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk iff (in_ch.valid && in_ch.ready));
    endtask

    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cfg(input cfg_t c);
        shadow_cfg = c;
        write_reg(REG_RED_COEF, c.red_coef);
        write_reg(REG_BLUE_COEF, c.blue_coef);
        write_reg(REG_GCB_COEF, c.gcb_coef);
        write_reg(REG_GCR_COEF, c.gcr_coef);
        write_reg(REG_CB_SCALE, 18'(c.cb_scale));
        write_reg(REG_CR_SCALE, 18'(c.cr_scale));
        write_reg(REG_CHROMA_MIN, 18'(c.chroma_min));
        write_reg(REG_CHROMA_MAX, 18'(c.chroma_max));
    endtask

    function automatic logic signed [17:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 18'($urandom);
            1: return 18'($signed(12'($urandom)));
            2: return 18'($signed(16'($urandom)));
            default: return 18'($signed(9'($urandom)));
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.req_type = ($urandom_range(0, 5) == 0) ? 1'b1 : 1'b0;
        if ($urandom_range(0, 7) == 0)
            it.y_top_left[9:0] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        if ($urandom_range(0, 7) == 0)
            it.cb_code[9:0] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        return it;
    endfunction

    function automatic in_item_t blk(input logic [15:0] cb, cr, yl, yr, bl, br);
        in_item_t it;
        it = '0;
        it.cb_code = cb;
        it.cr_code = cr;
        it.y_top_left = yl;
        it.y_top_right = yr;
        it.y_bottom_left = bl;
        it.y_bottom_right = br;
        return it;
    endfunction

    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        in_item_t it;
        cfg_t c;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        fail_seen = 1'b0;
        quiet_mode = 1'b0;
        hold_req = 1'b0;
        use_typed = 1'b0;
        typed_exp = '0;
        shadow_cfg = '{red_coef: 0, blue_coef: 0, gcb_coef: 0, gcr_coef: 0,
                       cb_scale: 256, cr_scale: 256, chroma_min: 16, chroma_max: 240};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every curve entry gets written first, as a ramp
        for (int i = 0; i < 1024; i++)
        begin
            it = '0;
            it.req_type = 1'b1;
            it.lut_index = 10'(i);
            it.lut_value = 8'(i >> 2);
            send_item(it);
        end

        // directed rows under reset registers
        row.has_exp = 1'b1;
        row.item = blk(16'h0200, 16'h0200, 0, 0, 0, 0);
        row.exp = '{0, 0, 0, 0, 128, 128};
        rows.push_back(row);
        row.item = blk(16'hFE00, 16'hFE00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        row.exp = '{255, 255, 255, 255, 128, 128};
        rows.push_back(row);
        row.item = blk(16'hFC00, 16'h03FF, 16'hFC00, 16'h03FF, 16'h0155, 16'h02AA);
        row.exp = '{0, 255, 85, 170, 128, 128};
        rows.push_back(row);
        row.has_exp = 1'b0;
        row.item = blk(16'h0000, 16'h03FF, 1, 512, 1022, 300);
        rows.push_back(row);
        row.item = blk(16'h03FF, 16'h0000, 700, 0, 1023, 5);
        rows.push_back(row);
        // table load in the middle of blocks, then a block that reads it
        row.item = '0;
        row.item.req_type = 1'b1;
        row.item.lut_index = 10'h3FF;
        row.item.lut_value = 8'h00;
        rows.push_back(row);
        row.item = blk(16'h0200, 16'h0200, 16'h03FF, 0, 16'h03FF, 16'h8000);
        rows.push_back(row);
        row.item = '0;
        row.item.req_type = 1'b1;
        row.item.lut_index = 10'h3FF;
        row.item.lut_value = 8'hFF;
        rows.push_back(row);
        row.item = blk(16'h0201, 16'h01FF, 16'h0100, 16'h0200, 16'h0300, 16'h03FE);
        rows.push_back(row);
        foreach (rows[i])
        begin
            use_typed <= rows[i].has_exp;
            typed_exp <= rows[i].exp;
            send_item(rows[i].item);
        end
        use_typed <= 1'b0;
        drain_pipe();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: c = '{131071, 131071, 131071, 131071, 1023, 1023, 0, 255};
                1: c = '{-131072, -131072, -131072, -131072, 0, 0, 255, 0};
                2: c = '{-131072, 131071, 131071, -131072, 1023, 0, 0, 0};
                default: c = '{rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                               10'($urandom), 10'($urandom), 8'($urandom_range(0, 60)),
                               8'($urandom_range(180, 255))};
            endcase
            load_cfg(c);
            quiet_mode = (ph == 7);
            if (ph == 1)
            begin
                // chroma edge blocks under extreme coefficients
                send_item(blk(16'h0000, 16'h0000, 0, 1023, 512, 16'hFFFF));
                send_item(blk(16'h03FF, 16'h03FF, 1023, 0, 511, 16'h0001));
            end
            if (ph == 3)
                hold_req = 1'b1;
            for (int n = 0; n < 96; n++)
                send_item(rand_item());
            drain_pipe();
        end

        repeat (20) @(posedge clk);
        if (!fail_seen && pending_q.size() == 0)
            $display("hdr_to_sdr_tonemap_2x2 verification clean");
        else
            $display("hdr_to_sdr_tonemap_2x2 verification failed");
        $finish;
    end
endmodule
`default_nettype wire
